>>> hw/rtl/bfha_pkg.sv
package bfha_pkg;

   localparam int unsigned START_W = 16;
   localparam int unsigned LEN_W   = 17;
   localparam int unsigned AGE_W   = 32;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NO_FIT     = 3'd1,
      ST_UNKNOWN    = 3'd2,
      ST_TABLE_FULL = 3'd3,
      ST_ZERO_SIZE  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_USCAN,
      S_HSCAN,
      S_WRITE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [0:0]  operation;
      logic [16:0] request_size;
      logic [15:0] block_offset;
   } req_type;

   typedef struct packed {
      logic [15:0] granted_offset;
      logic [2:0]  status;
      logic [16:0] allocated_total;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
      logic [AGE_W-1:0]   age;
   } hole_type;

   typedef struct packed {
      logic               valid;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
   } used_type;

   typedef struct packed {
      logic init;
      logic shift;
   } ring_ctl_type;

endpackage

>>> hw/rtl/bfha_hole_cell.sv
module bfha_hole_cell #(
   parameter bit FIRST = 1'b0
) (
   input  logic                  clock,
   input  bfha_pkg::ring_ctl_type ctl,
   input  logic [16:0]           heap_size,
   input  bfha_pkg::hole_type    din,
   output bfha_pkg::hole_type    q
);
   import bfha_pkg::*;

   hole_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.init) begin
         entry_in.valid = FIRST;
         entry_in.start = '0;
         entry_in.len   = heap_size;
         entry_in.age   = '0;
      end else if (ctl.shift) begin
         entry_in = din;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

>>> hw/rtl/bfha_used_cell.sv
module bfha_used_cell (
   input  logic                  clock,
   input  bfha_pkg::ring_ctl_type ctl,
   input  bfha_pkg::used_type    din,
   output bfha_pkg::used_type    q
);
   import bfha_pkg::*;

   used_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.init) begin
         entry_in.valid = 1'b0;
      end else if (ctl.shift) begin
         entry_in = din;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

>>> hw/rtl/best_fit_heap_allocator_unit.sv
// Channel   Ports                                Handshake
// request   start, busy, req_data                taken when start & !busy
// result    rsp_valid, rsp_data                  one-cycle strobe, no stall
// config    csr_valid, csr_ready, csr_data       written when valid & ready
//
// Both tables are rings of cells that rotate one entry per cycle past a head during scan and write passes.
// Allocate: hole scan, rotate-write, respond; zero size goes straight to respond.
// Free: used scan, hole scan, rotate-write, respond; unknown offset skips to respond.
// Reset and a heap_size write rebuild the tables at the next clock edge.
// Config is taken only while idle; results cannot be stalled.
module best_fit_heap_allocator_unit #(
   parameter int unsigned MAX_BLOCKS  = 32,
   parameter int unsigned OFFSET_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bfha_pkg::req_type req_data,
   output logic              rsp_valid,
   output bfha_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [16:0]       csr_data
);
   import bfha_pkg::*;

   localparam int unsigned HS  = MAX_BLOCKS + 1;
   localparam int unsigned HIW = $clog2(HS);
   localparam int unsigned UIW = $clog2(MAX_BLOCKS);
   localparam logic [16:0] HEAP_TOP =
      (OFFSET_BITS >= 16) ? 17'h10000 : 17'(1 << OFFSET_BITS);
   localparam logic [HIW-1:0] HLAST = HIW'(HS - 1);
   localparam logic [HIW-1:0] ULAST = HIW'(MAX_BLOCKS - 1);
   localparam logic [HIW-1:0] UCNT  = HIW'(MAX_BLOCKS);

   state_type state_ff, state_in;
   logic [HIW-1:0] cnt_ff, cnt_in;
   logic [16:0] heap_ff, heap_in;
   logic [AGE_W-1:0] age_ff, age_in;
   logic [16:0] total_ff, total_in;
   req_type req_ff, req_in;
   logic [2:0] status_ff, status_in;

   // search results
   logic best_found_ff, best_found_in;
   logic [HIW-1:0] best_idx_ff, best_idx_in;
   logic [LEN_W-1:0] best_len_ff, best_len_in;
   logic [AGE_W-1:0] best_age_ff, best_age_in;
   logic [START_W-1:0] best_start_ff, best_start_in;
   logic uslot_found_ff, uslot_found_in;
   logic [UIW-1:0] uslot_idx_ff, uslot_idx_in;
   logic [LEN_W-1:0] blk_len_ff, blk_len_in;
   logic lower_found_ff, lower_found_in;
   logic [HIW-1:0] lower_idx_ff, lower_idx_in;
   logic [START_W-1:0] lower_start_ff, lower_start_in;
   logic upper_found_ff, upper_found_in;
   logic [HIW-1:0] upper_idx_ff, upper_idx_in;
   logic [16:0] upper_end_ff, upper_end_in;
   logic hfree_found_ff, hfree_found_in;
   logic [HIW-1:0] hfree_idx_ff, hfree_idx_in;

   ring_ctl_type hctl, uctl;
   hole_type hq [HS];
   used_type uq [MAX_BLOCKS];
   hole_type htail;
   used_type utail;
   hole_type hhead;
   used_type uhead;

   logic [16:0] clamp_val;
   logic [16:0] head_end, free_lo, free_hi;
   logic [HIW-1:0] wslot;
   logic lower_hit, upper_hit, ucnt_live;
   logic [UIW-1:0] ucnt;

   assign hhead = hq[0];
   assign uhead = uq[0];
   assign ucnt_live = cnt_ff < UCNT;
   assign ucnt = cnt_ff[UIW-1:0];
   assign head_end = {1'b0, hhead.start} + hhead.len;
   assign free_lo = {1'b0, req_ff.block_offset};
   assign free_hi = free_lo + blk_len_ff;

   always_comb begin
      clamp_val = csr_data;
      if (csr_data == '0) clamp_val = 17'd1;
      else if (csr_data > HEAP_TOP) clamp_val = HEAP_TOP;
   end

   assign wslot = lower_found_ff ? lower_idx_ff
                : (upper_found_ff ? upper_idx_ff : hfree_idx_ff);
   assign lower_hit = hhead.valid && !lower_found_ff && head_end == free_lo;
   assign upper_hit = hhead.valid && !lower_hit && !upper_found_ff &&
                      {1'b0, hhead.start} == free_hi;

   // ring feedback: head goes to the tail, edited during the write pass
   always_comb begin
      htail = hhead;
      utail = uhead;
      if (state_ff == S_WRITE) begin
         if (req_ff.operation == OP_ALLOC) begin
            if (cnt_ff == best_idx_ff) begin
               if (best_len_ff == req_ff.request_size) begin
                  htail.valid = 1'b0;
               end else begin
                  htail.start = hhead.start + req_ff.request_size[START_W-1:0];
                  htail.len   = hhead.len - req_ff.request_size;
                  htail.age   = age_ff;
               end
            end
            if (ucnt_live && ucnt == uslot_idx_ff) begin
               utail.valid = 1'b1;
               utail.start = best_start_ff;
               utail.len   = req_ff.request_size;
            end
         end else begin
            if (cnt_ff == wslot) begin
               htail.valid = 1'b1;
               htail.start = lower_found_ff ? lower_start_ff : req_ff.block_offset;
               htail.len   = (upper_found_ff ? upper_end_ff : free_hi)
                           - (lower_found_ff ? {1'b0, lower_start_ff} : free_lo);
               htail.age   = age_ff;
            end else if (upper_found_ff && cnt_ff == upper_idx_ff) begin
               htail.valid = 1'b0;
            end
            if (ucnt_live && ucnt == uslot_idx_ff) begin
               utail.valid = 1'b0;
            end
         end
      end
   end

   always_comb begin
      hctl.init  = reset || (csr_valid && csr_ready);
      uctl.init  = hctl.init;
      hctl.shift = state_ff == S_HSCAN || state_ff == S_WRITE;
      uctl.shift = (state_ff == S_USCAN) ||
                   ((state_ff == S_HSCAN || state_ff == S_WRITE) && ucnt_live &&
                    !(state_ff == S_HSCAN && req_ff.operation == OP_FREE));
   end

   for (genvar i = 0; i < HS; i++) begin : g_hole
      bfha_hole_cell #(.FIRST(i == 0)) u_cell (
         .clock     (clock),
         .ctl       (hctl),
         .heap_size (reset ? 17'h10000 & HEAP_TOP | (HEAP_TOP & ~17'h10000)
                           : clamp_val),
         .din       ((i == HS - 1) ? htail : hq[(i + 1) % HS]),
         .q         (hq[i])
      );
   end

   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_used
      bfha_used_cell u_cell (
         .clock (clock),
         .ctl   (uctl),
         .din   ((i == MAX_BLOCKS - 1) ? utail : uq[(i + 1) % MAX_BLOCKS]),
         .q     (uq[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      heap_in = heap_ff;
      age_in = age_ff;
      total_in = total_ff;
      req_in = req_ff;
      status_in = status_ff;
      best_found_in = best_found_ff;
      best_idx_in = best_idx_ff;
      best_len_in = best_len_ff;
      best_age_in = best_age_ff;
      best_start_in = best_start_ff;
      uslot_found_in = uslot_found_ff;
      uslot_idx_in = uslot_idx_ff;
      blk_len_in = blk_len_ff;
      lower_found_in = lower_found_ff;
      lower_idx_in = lower_idx_ff;
      lower_start_in = lower_start_ff;
      upper_found_in = upper_found_ff;
      upper_idx_in = upper_idx_ff;
      upper_end_in = upper_end_ff;
      hfree_found_in = hfree_found_ff;
      hfree_idx_in = hfree_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               heap_in = clamp_val;
               age_in = '0;
               total_in = '0;
            end
            if (start) begin
               req_in = req_data;
               cnt_in = '0;
               best_found_in = 1'b0;
               uslot_found_in = 1'b0;
               lower_found_in = 1'b0;
               upper_found_in = 1'b0;
               hfree_found_in = 1'b0;
               if (req_data.operation == OP_FREE) begin
                  state_in = S_USCAN;
               end else if (req_data.request_size == '0) begin
                  status_in = ST_ZERO_SIZE;
                  state_in = S_RESP;
               end else begin
                  state_in = S_HSCAN;
               end
            end
         end
         S_USCAN: begin
            if (uhead.valid && !uslot_found_in && uhead.start == req_ff.block_offset) begin
               uslot_found_in = 1'b1;
               uslot_idx_in = ucnt;
               blk_len_in = uhead.len;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ULAST) begin
               cnt_in = '0;
               if (uslot_found_in) begin
                  state_in = S_HSCAN;
               end else begin
                  status_in = ST_UNKNOWN;
                  state_in = S_RESP;
               end
            end
         end
         S_HSCAN: begin
            if (req_ff.operation == OP_ALLOC) begin
               if (hhead.valid && hhead.len >= req_ff.request_size &&
                   (!best_found_ff || hhead.len < best_len_ff ||
                    (hhead.len == best_len_ff && hhead.age < best_age_ff))) begin
                  best_found_in = 1'b1;
                  best_idx_in = cnt_ff;
                  best_len_in = hhead.len;
                  best_age_in = hhead.age;
                  best_start_in = hhead.start;
               end
               if (ucnt_live && !uhead.valid && !uslot_found_ff) begin
                  uslot_found_in = 1'b1;
                  uslot_idx_in = ucnt;
               end
            end else begin
               if (lower_hit) begin
                  lower_found_in = 1'b1;
                  lower_idx_in = cnt_ff;
                  lower_start_in = hhead.start;
               end
               if (upper_hit) begin
                  upper_found_in = 1'b1;
                  upper_idx_in = cnt_ff;
                  upper_end_in = head_end;
               end
               if (!hhead.valid && !hfree_found_ff) begin
                  hfree_found_in = 1'b1;
                  hfree_idx_in = cnt_ff;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == HLAST) begin
               cnt_in = '0;
               state_in = S_RESP;
               if (req_ff.operation == OP_ALLOC) begin
                  if (!best_found_in) status_in = ST_NO_FIT;
                  else if (!uslot_found_in) status_in = ST_TABLE_FULL;
                  else begin
                     status_in = ST_OK;
                     state_in = S_WRITE;
                  end
               end else begin
                  if (!lower_found_in && !upper_found_in && !hfree_found_in) begin
                     status_in = ST_TABLE_FULL;
                  end else begin
                     status_in = ST_OK;
                     state_in = S_WRITE;
                  end
               end
            end
         end
         S_WRITE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == HLAST) begin
               cnt_in = '0;
               state_in = S_RESP;
               if (req_ff.operation == OP_ALLOC) begin
                  total_in = total_ff + req_ff.request_size;
                  if (best_len_ff != req_ff.request_size) age_in = age_ff + 1'b1;
               end else begin
                  total_in = total_ff - blk_len_ff;
                  age_in = age_ff + 1'b1;
               end
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         heap_ff <= HEAP_TOP;
         age_ff <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         heap_ff <= heap_in;
         age_ff <= age_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      status_ff <= status_in;
      best_found_ff <= best_found_in;
      best_idx_ff <= best_idx_in;
      best_len_ff <= best_len_in;
      best_age_ff <= best_age_in;
      best_start_ff <= best_start_in;
      uslot_found_ff <= uslot_found_in;
      uslot_idx_ff <= uslot_idx_in;
      blk_len_ff <= blk_len_in;
      lower_found_ff <= lower_found_in;
      lower_idx_ff <= lower_idx_in;
      lower_start_ff <= lower_start_in;
      upper_found_ff <= upper_found_in;
      upper_idx_ff <= upper_idx_in;
      upper_end_ff <= upper_end_in;
      hfree_found_ff <= hfree_found_in;
      hfree_idx_ff <= hfree_idx_in;
   end

   assign busy = state_ff != S_IDLE;
   assign csr_ready = !busy;
   assign rsp_valid = state_ff == S_RESP;
   assign rsp_data.status = status_ff;
   assign rsp_data.allocated_total = total_ff;
   assign rsp_data.granted_offset =
      (status_ff == ST_OK && req_ff.operation == OP_ALLOC) ? best_start_ff : '0;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.allocated_total <= heap_ff)
      else $error("allocated total exceeds heap size");
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> rsp_data.granted_offset == '0)
      else $error("nonzero offset on failed request");

endmodule

>>> dv/best_fit_heap_allocator_unit_checker.sv
`timescale 1ns / 100ps

module best_fit_heap_allocator_unit_checker #(
   parameter int unsigned MAX_BLOCKS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  bfha_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  bfha_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [16:0]       csr_data,
   output int                fail_count,
   output int                pending
);
   import bfha_pkg::*;

   localparam int unsigned FREE_SLOTS = MAX_BLOCKS + 1;

   int unsigned heap_bytes;
   int unsigned blk_start [MAX_BLOCKS];
   int unsigned blk_len   [MAX_BLOCKS];
   bit          blk_live  [MAX_BLOCKS];
   int unsigned gap_start [FREE_SLOTS];
   int unsigned gap_len   [FREE_SLOTS];
   bit [31:0]   gap_age   [FREE_SLOTS];
   bit          gap_live  [FREE_SLOTS];
   bit [31:0]   next_age;
   int unsigned bytes_in_use;
   rsp_type     expected_rsp [$];

   function automatic void rebuild_heap(input int unsigned value);
      heap_bytes = (value < 1) ? 1 : (value > 65536) ? 65536 : value;
      for (int i = 0; i < MAX_BLOCKS; i++) blk_live[i] = 1'b0;
      for (int i = 0; i < FREE_SLOTS; i++) begin
         gap_start[i] = 0;
         gap_len[i]   = 0;
         gap_age[i]   = '0;
         gap_live[i]  = 1'b0;
      end
      gap_len[0]   = heap_bytes;
      gap_live[0]  = 1'b1;
      next_age     = '0;
      bytes_in_use = 0;
   endfunction

   function automatic status_type grant_block(input int unsigned size,
                                              output int unsigned where);
      int best;
      int slot;
      best  = -1;
      slot  = -1;
      where = 0;
      if (size == 0) return ST_ZERO_SIZE;
      for (int i = 0; i < FREE_SLOTS; i++) begin
         if (!gap_live[i] || gap_len[i] < size) continue;
         if (best < 0 || gap_len[i] < gap_len[best] ||
             (gap_len[i] == gap_len[best] && gap_age[i] < gap_age[best]))
            best = i;
      end
      if (best < 0) return ST_NO_FIT;
      for (int i = 0; i < MAX_BLOCKS; i++)
         if (!blk_live[i] && slot < 0) slot = i;
      if (slot < 0) return ST_TABLE_FULL;
      where = gap_start[best];
      if (gap_len[best] == size) begin
         gap_live[best] = 1'b0;
      end else begin
         gap_start[best] += size;
         gap_len[best]   -= size;
         gap_age[best]    = next_age;
         next_age++;
      end
      blk_start[slot] = where;
      blk_len[slot]   = size;
      blk_live[slot]  = 1'b1;
      bytes_in_use   += size;
      return ST_OK;
   endfunction

   function automatic status_type release_block(input int unsigned offset);
      int blk, lower, upper, slot;
      int unsigned lo, hi;
      blk = -1; lower = -1; upper = -1; slot = -1;
      for (int i = 0; i < MAX_BLOCKS; i++)
         if (blk < 0 && blk_live[i] && blk_start[i] == offset) blk = i;
      if (blk < 0) return ST_UNKNOWN;
      lo = blk_start[blk];
      hi = lo + blk_len[blk];
      for (int i = 0; i < FREE_SLOTS; i++) begin
         if (!gap_live[i]) continue;
         if (lower < 0 && gap_start[i] + gap_len[i] == lo) lower = i;
         else if (upper < 0 && gap_start[i] == hi) upper = i;
      end
      if (lower < 0 && upper < 0) begin
         for (int i = 0; i < FREE_SLOTS; i++)
            if (slot < 0 && !gap_live[i]) slot = i;
         if (slot < 0) return ST_TABLE_FULL;
      end
      if (lower >= 0) begin
         lo = gap_start[lower];
         gap_live[lower] = 1'b0;
         slot = lower;
      end
      if (upper >= 0) begin
         hi = gap_start[upper] + gap_len[upper];
         gap_live[upper] = 1'b0;
         if (slot < 0) slot = upper;
      end
      gap_start[slot] = lo;
      gap_len[slot]   = hi - lo;
      gap_age[slot]   = next_age;
      gap_live[slot]  = 1'b1;
      next_age++;
      bytes_in_use   -= blk_len[blk];
      blk_live[blk]   = 1'b0;
      return ST_OK;
   endfunction

   function automatic rsp_type predict_result(input req_type r);
      rsp_type     p;
      status_type  st;
      int unsigned where;
      where = 0;
      if (r.operation == OP_ALLOC) st = grant_block(r.request_size, where);
      else st = release_block(r.block_offset);
      if (st != ST_OK || r.operation == OP_FREE) where = 0;
      p.granted_offset  = where[15:0];
      p.status          = st;
      p.allocated_total = bytes_in_use[16:0];
      return p;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      int      errs;
      errs = 0;
      if (reset) begin
         rebuild_heap(65536);
         expected_rsp.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) rebuild_heap(csr_data);
         if (start && !busy) expected_rsp.push_back(predict_result(req_data));
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $error("result beat with nothing expected");
               errs++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.granted_offset !== e.granted_offset) begin
                  $error("granted_offset expected %0d got %0d",
                         e.granted_offset, rsp_data.granted_offset);
                  errs++;
               end
               if (rsp_data.status !== e.status) begin
                  $error("status expected %0d got %0d", e.status, rsp_data.status);
                  errs++;
               end
               if (rsp_data.allocated_total !== e.allocated_total) begin
                  $error("allocated_total expected %0d got %0d",
                         e.allocated_total, rsp_data.allocated_total);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
      pending <= expected_rsp.size();
   end

endmodule

>>> dv/best_fit_heap_allocator_unit_test.sv
`timescale 1ns / 100ps

module best_fit_heap_allocator_unit_test;
   import bfha_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1500000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [16:0] csr_data;
   int          fail_count;
   int          pending;
   int unsigned cycle_count = 0;
   int unsigned heap_now;
   req_type     sent_reqs [$];
   int unsigned live_offsets [$];

   best_fit_heap_allocator_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   best_fit_heap_allocator_unit_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // track live blocks so that most frees hit real offsets
   always @(posedge clock) begin
      req_type r;
      if (!reset && rsp_valid && sent_reqs.size() != 0) begin
         r = sent_reqs.pop_front();
         if (rsp_data.status == ST_OK) begin
            if (r.operation == OP_ALLOC) live_offsets.push_back(rsp_data.granted_offset);
            else
               foreach (live_offsets[i])
                  if (live_offsets[i] == r.block_offset) begin
                     live_offsets.delete(i);
                     break;
                  end
         end
      end
   end

   task automatic send(input op_type op, input int unsigned size, input int unsigned off);
      req_type r;
      r.operation    = op;
      r.request_size = size[16:0];
      r.block_offset = off[15:0];
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sent_reqs.push_back(r);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_heap(input int unsigned value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value[16:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      heap_now = (value[16:0] < 1) ? 1 : (value[16:0] > 65536) ? 65536 : value[16:0];
      live_offsets.delete();
   endtask

   task automatic random_item();
      int unsigned pick;
      int unsigned size;
      pick = $urandom_range(99);
      if (live_offsets.size() != 0 && pick < 45) begin
         if ($urandom_range(9) < 8)
            send(OP_FREE, $urandom, live_offsets[$urandom_range(live_offsets.size() - 1)]);
         else
            send(OP_FREE, $urandom, $urandom_range(65535));
      end else begin
         pick = $urandom_range(99);
         if (pick < 70) size = $urandom_range(1, (heap_now / 12 > 1) ? heap_now / 12 : 1);
         else if (pick < 80) size = $urandom_range(1, heap_now);
         else if (pick < 85) size = 0;
         else if (pick < 90) size = $urandom_range(heap_now, 131071);
         else size = $urandom_range(131071);
         send(OP_ALLOC, size, $urandom_range(65535));
      end
   endtask

   initial begin
      int unsigned heaps [8] = '{65536, 1, 0, 131071, 100, 4096, 40000, 777};
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      heap_now    = 65536;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // heap end, merges, zero size and oversize cases
      send(OP_ALLOC, 65535, 0);
      send(OP_ALLOC, 1, 0);
      send(OP_ALLOC, 1, 0);
      send(OP_FREE, 0, 65535);
      send(OP_FREE, 0, 0);
      send(OP_ALLOC, 0, 65535);
      send(OP_ALLOC, 65537, 0);
      send(OP_ALLOC, 131071, 65535);
      send(OP_FREE, 131071, 1234);
      send(OP_ALLOC, 65536, 0);
      send(OP_FREE, 0, 65535);
      send(OP_FREE, 0, 0);
      send(OP_ALLOC, 100, 0);
      send(OP_ALLOC, 200, 0);
      send(OP_ALLOC, 100, 0);
      send(OP_FREE, 0, 100);
      send(OP_ALLOC, 150, 0);
      send(OP_FREE, 0, 0);
      send(OP_FREE, 0, 300);
      send(OP_FREE, 0, 100);
      send(OP_ALLOC, 50, 0);
      send(OP_FREE, 0, 65535);

      for (int p = 0; p < 8; p++) begin
         if (p != 0) write_heap(heaps[p] == 777 ? $urandom_range(1, 65536) : heaps[p]);
         for (int n = 0; n < 215; n++) begin
            if (p != 2 && $urandom_range(99) < 12) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 60)) @(posedge clock);
            end
            if (p == 5 && n == 100) drain();
            random_item();
         end
      end

      drain();
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> best_fit_heap_allocator_unit.f
hw/rtl/bfha_pkg.sv
hw/rtl/bfha_hole_cell.sv
hw/rtl/bfha_used_cell.sv
hw/rtl/best_fit_heap_allocator_unit.sv
dv/best_fit_heap_allocator_unit_checker.sv
dv/best_fit_heap_allocator_unit_test.sv
